/* rtl/obb_sat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared types and constants for the oriented box separating axis test.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

	// number of test axes: reference axis 0/1, query axis 0/1
	localparam int NumAxes = 4;

	// field widths
	localparam int CenterW = 32;
	localparam int HalfW   = 31;
	localparam int AxisW   = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	// derived widths of intermediate values
	localparam int CprodW = CenterW + AxisW;       // center times axis component
	localparam int ProjW  = CprodW + 1;            // center projection
	localparam int DprodW = 2 * AxisW;             // axis component product
	localparam int DotW   = DprodW + 1;            // signed axis dot product
	localparam int DabsW  = DprodW;                // magnitude of axis dot product
	localparam int DiffW  = ProjW + 1;             // difference of projections
	localparam int DistW  = DiffW - 1;             // magnitude of difference
	localparam int DistShift = 14;                 // Q.30 to Q.44
	localparam int DistQW = DistW + DistShift;     // distance in Q.44
	localparam int RprodW = HalfW + DabsW;         // half extent times |dot|
	localparam int RadW   = RprodW + 1;            // radius of one box
	localparam int RsumW  = RadW + 1;              // sum of both radii

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_REF_CENTER_X = 3'd0,
		REG_REF_CENTER_Y = 3'd1,
		REG_REF_HALF_X   = 3'd2,
		REG_REF_HALF_Y   = 3'd3,
		REG_REF_AXIS0_X  = 3'd4,
		REG_REF_AXIS0_Y  = 3'd5,
		REG_REF_AXIS1_X  = 3'd6,
		REG_REF_AXIS1_Y  = 3'd7
	} cfg_reg_t;

	// reset values of the reference box
	localparam logic signed [AxisW-1:0] AxisOne  = 16'sd16384;
	localparam logic signed [AxisW-1:0] AxisZero = 16'sd0;

	// per-axis intermediate types
	typedef logic signed [AxisW-1:0]  axis_comp_t;
	typedef logic signed [CprodW-1:0] cprod_t;
	typedef logic signed [DprodW-1:0] dprod_t;
	typedef logic signed [ProjW-1:0]  proj_t;
	typedef logic        [DabsW-1:0]  dabs_t;
	typedef logic        [DistQW-1:0] dist_t;
	typedef logic        [RprodW-1:0] rprod_t;
	typedef logic        [RadW-1:0]   rad_t;

endpackage

/* rtl/obb_separating_axis_overlap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_separating_axis_overlap
// Five-stage pipelined separating axis test of a query box against a
// reference box held in configuration registers.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; each stage holds only while the
// stage after it is full and stalled.
// Reset: clears all stage valid bits and loads the reference box with a zero
// center, zero half extents and unit axes along x and y.
module obb_separating_axis_overlap (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write port
	input  logic                                    cfg_we,
	input  logic [obb_sat_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [obb_sat_pkg::CfgDataW-1:0]        cfg_data,
	// query box channel
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [obb_sat_pkg::CenterW-1:0]  box_center_x,
	input  logic signed [obb_sat_pkg::CenterW-1:0]  box_center_y,
	input  logic        [obb_sat_pkg::HalfW-1:0]    box_half_x,
	input  logic        [obb_sat_pkg::HalfW-1:0]    box_half_y,
	input  logic signed [obb_sat_pkg::AxisW-1:0]    box_axis0_x,
	input  logic signed [obb_sat_pkg::AxisW-1:0]    box_axis0_y,
	input  logic signed [obb_sat_pkg::AxisW-1:0]    box_axis1_x,
	input  logic signed [obb_sat_pkg::AxisW-1:0]    box_axis1_y,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    overlap
);
	import obb_sat_pkg::*;

	// reference box registers
	logic signed [CenterW-1:0] ref_center_x_q, ref_center_y_q;
	logic        [HalfW-1:0]   ref_half_x_q, ref_half_y_q;
	axis_comp_t                ref_axis0_x_q, ref_axis0_y_q;
	axis_comp_t                ref_axis1_x_q, ref_axis1_y_q;

	// stage valid bits and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	// axis components of all four axes, indexed the same way as test axes
	axis_comp_t ax [NumAxes];
	axis_comp_t ay [NumAxes];

	// stage 1: products
	cprod_t cpa_x_s1 [NumAxes], cpa_y_s1 [NumAxes];
	cprod_t cpb_x_s1 [NumAxes], cpb_y_s1 [NumAxes];
	dprod_t dp_x_s1 [NumAxes][NumAxes];
	dprod_t dp_y_s1 [NumAxes][NumAxes];
	logic [HalfW-1:0] half_x_s1, half_y_s1;

	// stage 2: projections and dot magnitudes
	proj_t  pa_s2 [NumAxes], pb_s2 [NumAxes];
	dabs_t  dabs_s2 [NumAxes][NumAxes];
	logic [HalfW-1:0] half_x_s2, half_y_s2;

	// stage 3: distance and radius products
	dist_t  dist_s3 [NumAxes];
	rprod_t rp_s3 [NumAxes][NumAxes];

	// stage 4: radii per box
	dist_t  dist_s4 [NumAxes];
	rad_t   ra_s4 [NumAxes], rb_s4 [NumAxes];

	// stage 5: result
	logic   overlap_s5;

	// combinational next values
	cprod_t cpa_x_d [NumAxes], cpa_y_d [NumAxes];
	cprod_t cpb_x_d [NumAxes], cpb_y_d [NumAxes];
	dprod_t dp_x_d [NumAxes][NumAxes];
	dprod_t dp_y_d [NumAxes][NumAxes];
	proj_t  pa_d [NumAxes], pb_d [NumAxes];
	dabs_t  dabs_d [NumAxes][NumAxes];
	dist_t  dist_d [NumAxes];
	rprod_t rp_d [NumAxes][NumAxes];
	rad_t   ra_d [NumAxes], rb_d [NumAxes];
	logic   overlap_d;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_center_x_q <= '0;
			ref_center_y_q <= '0;
			ref_half_x_q   <= '0;
			ref_half_y_q   <= '0;
			ref_axis0_x_q  <= AxisOne;
			ref_axis0_y_q  <= AxisZero;
			ref_axis1_x_q  <= AxisZero;
			ref_axis1_y_q  <= AxisOne;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REF_CENTER_X: ref_center_x_q <= cfg_data[CenterW-1:0];
				REG_REF_CENTER_Y: ref_center_y_q <= cfg_data[CenterW-1:0];
				REG_REF_HALF_X:   ref_half_x_q   <= cfg_data[HalfW-1:0];
				REG_REF_HALF_Y:   ref_half_y_q   <= cfg_data[HalfW-1:0];
				REG_REF_AXIS0_X:  ref_axis0_x_q  <= cfg_data[AxisW-1:0];
				REG_REF_AXIS0_Y:  ref_axis0_y_q  <= cfg_data[AxisW-1:0];
				REG_REF_AXIS1_X:  ref_axis1_x_q  <= cfg_data[AxisW-1:0];
				REG_REF_AXIS1_Y:  ref_axis1_y_q  <= cfg_data[AxisW-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next stage advances
	assign adv5     = !valid_s5 || !out_stall;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// gather the four axes: reference 0, reference 1, query 0, query 1
	always_comb begin
		ax[0] = ref_axis0_x_q;
		ay[0] = ref_axis0_y_q;
		ax[1] = ref_axis1_x_q;
		ay[1] = ref_axis1_y_q;
		ax[2] = box_axis0_x;
		ay[2] = box_axis0_y;
		ax[3] = box_axis1_x;
		ay[3] = box_axis1_y;
	end

	// stage 1: center and axis component products
	always_comb begin
		for (int k = 0; k < NumAxes; k++) begin
			cpa_x_d[k] = CprodW'(ref_center_x_q) * CprodW'(ax[k]);
			cpa_y_d[k] = CprodW'(ref_center_y_q) * CprodW'(ay[k]);
			cpb_x_d[k] = CprodW'(box_center_x) * CprodW'(ax[k]);
			cpb_y_d[k] = CprodW'(box_center_y) * CprodW'(ay[k]);
			for (int j = 0; j < NumAxes; j++) begin
				dp_x_d[k][j] = DprodW'(ax[j]) * DprodW'(ax[k]);
				dp_y_d[k][j] = DprodW'(ay[j]) * DprodW'(ay[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cpa_x_s1  <= cpa_x_d;
			cpa_y_s1  <= cpa_y_d;
			cpb_x_s1  <= cpb_x_d;
			cpb_y_s1  <= cpb_y_d;
			dp_x_s1   <= dp_x_d;
			dp_y_s1   <= dp_y_d;
			half_x_s1 <= box_half_x;
			half_y_s1 <= box_half_y;
		end
	end

	// stage 2: sum into projections and take dot product magnitudes
	always_comb begin
		logic signed [DotW-1:0] dot;
		dot = '0;
		for (int k = 0; k < NumAxes; k++) begin
			pa_d[k] = ProjW'(cpa_x_s1[k]) + ProjW'(cpa_y_s1[k]);
			pb_d[k] = ProjW'(cpb_x_s1[k]) + ProjW'(cpb_y_s1[k]);
			for (int j = 0; j < NumAxes; j++) begin
				dot = DotW'(dp_x_s1[k][j]) + DotW'(dp_y_s1[k][j]);
				dabs_d[k][j] = dot[DotW-1] ? DabsW'(-dot) : DabsW'(dot);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pa_s2     <= pa_d;
			pb_s2     <= pb_d;
			dabs_s2   <= dabs_d;
			half_x_s2 <= half_x_s1;
			half_y_s2 <= half_y_s1;
		end
	end

	// stage 3: center distance in Q.44 and half extent times |dot|
	always_comb begin
		logic signed [DiffW-1:0] diff;
		logic        [DistW-1:0] mag;
		diff = '0;
		mag  = '0;
		for (int k = 0; k < NumAxes; k++) begin
			diff = DiffW'(pa_s2[k]) - DiffW'(pb_s2[k]);
			mag  = diff[DiffW-1] ? DistW'(-diff) : DistW'(diff);
			dist_d[k] = {mag, DistShift'(0)};
			rp_d[k][0] = RprodW'(ref_half_x_q) * RprodW'(dabs_s2[k][0]);
			rp_d[k][1] = RprodW'(ref_half_y_q) * RprodW'(dabs_s2[k][1]);
			rp_d[k][2] = RprodW'(half_x_s2) * RprodW'(dabs_s2[k][2]);
			rp_d[k][3] = RprodW'(half_y_s2) * RprodW'(dabs_s2[k][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			dist_s3 <= dist_d;
			rp_s3   <= rp_d;
		end
	end

	// stage 4: radius of each box on each axis
	always_comb begin
		for (int k = 0; k < NumAxes; k++) begin
			ra_d[k] = RadW'(rp_s3[k][0]) + RadW'(rp_s3[k][1]);
			rb_d[k] = RadW'(rp_s3[k][2]) + RadW'(rp_s3[k][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			dist_s4 <= dist_s3;
			ra_s4   <= ra_d;
			rb_s4   <= rb_d;
		end
	end

	// stage 5: an axis separates when the distance exceeds the radius sum
	always_comb begin
		logic [RsumW-1:0] rsum;
		logic             sep;
		rsum = '0;
		sep  = 1'b0;
		for (int k = 0; k < NumAxes; k++) begin
			rsum = RsumW'(ra_s4[k]) + RsumW'(rb_s4[k]);
			sep  = sep | (RsumW'(dist_s4[k]) > rsum);
		end
		overlap_d = !sep;
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			overlap_s5 <= overlap_d;
		end
	end

	assign out_valid = valid_s5;
	assign overlap   = overlap_s5;

endmodule
